// ----- hdl/sdmx_pkg.sv -----
package sdmx_pkg;

  localparam int unsigned NUM_SPEAKERS = 28;

  localparam int unsigned SPK_W   = 5;
  localparam int unsigned SMP_W   = 24;
  localparam int unsigned COEF_W  = 17;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned PROD_W  = ACC_W + COEF_W;
  localparam int unsigned FRAC_W  = 15;

  localparam int unsigned S_DATA_W = 64;
  localparam int unsigned M_DATA_W = 64;

  localparam logic [SPK_W-1:0] SPK_LEFT  = SPK_W'(1);
  localparam logic [SPK_W-1:0] SPK_RIGHT = SPK_W'(2);

  localparam logic [PROD_W-1:0] Q15_HALF = PROD_W'(1) << (FRAC_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_ACC1,
    ST_MUL2,
    ST_ACC2,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic mul_en;
    logic acc_en;
    logic step2;
    logic emit;
  } ctrl_t;

endpackage

// ----- hdl/sdmx_mul.sv -----
module sdmx_mul (
  input  logic                              clk_i,
  input  logic                              mul_en_i,
  input  logic signed [sdmx_pkg::ACC_W-1:0]  a_i,
  input  logic signed [sdmx_pkg::COEF_W-1:0] b_i,
  output logic [sdmx_pkg::ACC_W-1:0]         q_o
);

  logic signed [sdmx_pkg::PROD_W-1:0] a_ext;
  logic signed [sdmx_pkg::PROD_W-1:0] b_ext;
  logic signed [sdmx_pkg::PROD_W-1:0] prod_d;
  logic        [sdmx_pkg::PROD_W-1:0] prod_q;
  logic        [sdmx_pkg::PROD_W-1:0] rnd;

  // sign-extend both operands so the low bits of the product are exact
  assign a_ext  = {{(sdmx_pkg::PROD_W - sdmx_pkg::ACC_W){a_i[sdmx_pkg::ACC_W-1]}}, a_i};
  assign b_ext  = {{(sdmx_pkg::PROD_W - sdmx_pkg::COEF_W){b_i[sdmx_pkg::COEF_W-1]}}, b_i};
  assign prod_d = a_ext * b_ext;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // round half up, arithmetic shift by 15, keep 32 bits
  assign rnd = prod_q + sdmx_pkg::Q15_HALF;
  assign q_o = rnd[sdmx_pkg::FRAC_W +: sdmx_pkg::ACC_W];

endmodule

// ----- hdl/sdmx_ctrl.sv -----
module sdmx_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            last_i,
  input  logic            out_free_i,
  output logic            in_ready_o,
  output sdmx_pkg::ctrl_t ctrl_o
);

  sdmx_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdmx_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sdmx_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          state_d       = sdmx_pkg::ST_MUL1;
        end
      end
      sdmx_pkg::ST_MUL1: begin
        ctrl_o.mul_en = 1'b1;
        state_d       = sdmx_pkg::ST_ACC1;
      end
      sdmx_pkg::ST_ACC1: begin
        ctrl_o.acc_en = 1'b1;
        state_d       = sdmx_pkg::ST_MUL2;
      end
      sdmx_pkg::ST_MUL2: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.step2  = 1'b1;
        state_d       = sdmx_pkg::ST_ACC2;
      end
      sdmx_pkg::ST_ACC2: begin
        ctrl_o.acc_en = 1'b1;
        ctrl_o.step2  = 1'b1;
        if (!last_i) begin
          state_d = sdmx_pkg::ST_IDLE;
        end else if (out_free_i) begin
          ctrl_o.emit = 1'b1;
          state_d     = sdmx_pkg::ST_IDLE;
        end else begin
          state_d = sdmx_pkg::ST_OUT;
        end
      end
      sdmx_pkg::ST_OUT: begin
        if (out_free_i) begin
          ctrl_o.emit = 1'b1;
          state_d     = sdmx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sdmx_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/stereo_downmix_q15.sv -----
// stereo downmix of up to NUM_SPEAKERS speaker samples into one left/right pair, Q15 gains
//
// input stream: one transfer per present speaker of a sample time, in ascending
// speaker order; tuser carries the speaker index, tlast marks the last speaker.
// tdata holds the sample and its left and right gains. output stream: one
// transfer per sample time with the left and right sums in tdata and, in tuser,
// a flag that is set when the left or the right speaker did not show up.
//
// speaker transfers are taken one at a time. the single 32x17 multiplier
// is used twice per speaker (multiply, then round and accumulate, twice over),
// since the cross term of the left and right speakers needs the freshly
// updated sum. s_axis_tready is high only while the sequencer is idle.
// the result of a tlast transfer goes to the output register at its final step.
//
// reset clears the sequencer, the sums, the seen flags and the output valid.
// when the receiver stalls, the result waits in the output register; a later
// tlast transfer then holds at its final step until that register frees up,
// and no further speaker is taken meanwhile.
module stereo_downmix_q15 (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample [23:0], coef_left [40:24], coef_right [57:41], zero fill [63:58]
  input  logic [sdmx_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // speaker
  input  logic [sdmx_pkg::SPK_W-1:0]        s_axis_tuser,
  // last_speaker
  input  logic                              s_axis_tlast,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_out [31:0], right_out [63:32]
  output logic [sdmx_pkg::M_DATA_W-1:0]     m_axis_tdata,
  // stereo_missing
  output logic                              m_axis_tuser
);

  localparam int unsigned CL_LSB = sdmx_pkg::SMP_W;
  localparam int unsigned CR_LSB = sdmx_pkg::SMP_W + sdmx_pkg::COEF_W;

  sdmx_pkg::ctrl_t ctrl;

  // captured speaker transfer
  logic [sdmx_pkg::SPK_W-1:0]         spk_q;
  logic signed [sdmx_pkg::SMP_W-1:0]  smp_q;
  logic signed [sdmx_pkg::COEF_W-1:0] cl_q;
  logic signed [sdmx_pkg::COEF_W-1:0] cr_q;
  logic                               last_q;

  // running sums and seen flags
  logic [sdmx_pkg::ACC_W-1:0] left_q, left_d, left_upd;
  logic [sdmx_pkg::ACC_W-1:0] right_q, right_d, right_upd;
  logic                       seen_left_q, seen_left_d, seen_left_upd;
  logic                       seen_right_q, seen_right_d, seen_right_upd;

  // output register
  logic                        out_valid_q;
  logic [sdmx_pkg::ACC_W-1:0]  out_left_q;
  logic [sdmx_pkg::ACC_W-1:0]  out_right_q;
  logic                        out_missing_q;
  logic                        out_free;

  logic                               is_left;
  logic                               is_right;
  logic                               in_range;
  logic                               add_en;
  logic                               to_right;
  logic signed [sdmx_pkg::ACC_W-1:0]  smp_ext;
  logic signed [sdmx_pkg::ACC_W-1:0]  mul_a;
  logic signed [sdmx_pkg::COEF_W-1:0] mul_b;
  logic [sdmx_pkg::ACC_W-1:0]         mul_q;

  assign out_free = !out_valid_q || m_axis_tready;

  sdmx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .last_i     (last_q),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      spk_q  <= s_axis_tuser;
      smp_q  <= s_axis_tdata[sdmx_pkg::SMP_W-1:0];
      cl_q   <= s_axis_tdata[CL_LSB +: sdmx_pkg::COEF_W];
      cr_q   <= s_axis_tdata[CR_LSB +: sdmx_pkg::COEF_W];
      last_q <= s_axis_tlast;
    end
  end

  assign is_left  = (spk_q == sdmx_pkg::SPK_LEFT);
  assign is_right = (spk_q == sdmx_pkg::SPK_RIGHT);
  // indexes at or above the speaker count add nothing
  assign in_range = ({1'b0, spk_q} < (sdmx_pkg::SPK_W + 1)'(sdmx_pkg::NUM_SPEAKERS));
  assign smp_ext  = {{(sdmx_pkg::ACC_W - sdmx_pkg::SMP_W){smp_q[sdmx_pkg::SMP_W-1]}}, smp_q};

  // first pass: self gain of the left/right speaker, else the left gain
  // second pass: cross term from the updated sum, else the right gain
  always_comb begin
    if (!ctrl.step2) begin
      mul_a    = smp_ext;
      mul_b    = is_right ? cr_q : cl_q;
      to_right = is_right;
    end else begin
      priority if (is_left) begin
        mul_a = left_q;
      end else if (is_right) begin
        mul_a = right_q;
      end else begin
        mul_a = smp_ext;
      end
      mul_b    = is_right ? cl_q : cr_q;
      to_right = !is_right;
    end
  end

  sdmx_mul u_mul (
    .clk_i    (clk_i),
    .mul_en_i (ctrl.mul_en),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .q_o      (mul_q)
  );

  assign add_en = ctrl.acc_en && in_range;

  always_comb begin
    left_upd       = left_q;
    right_upd      = right_q;
    seen_left_upd  = seen_left_q;
    seen_right_upd = seen_right_q;
    if (add_en) begin
      if (to_right) begin
        right_upd = right_q + mul_q;
      end else begin
        left_upd = left_q + mul_q;
      end
      if (ctrl.step2) begin
        seen_left_upd  = seen_left_q || is_left;
        seen_right_upd = seen_right_q || is_right;
      end
    end
    // a sample time ends: hand the sums out and start over from zero
    if (ctrl.emit) begin
      left_d       = '0;
      right_d      = '0;
      seen_left_d  = 1'b0;
      seen_right_d = 1'b0;
    end else begin
      left_d       = left_upd;
      right_d      = right_upd;
      seen_left_d  = seen_left_upd;
      seen_right_d = seen_right_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      right_q      <= '0;
      seen_left_q  <= 1'b0;
      seen_right_q <= 1'b0;
    end else begin
      left_q       <= left_d;
      right_q      <= right_d;
      seen_left_q  <= seen_left_d;
      seen_right_q <= seen_right_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_left_q    <= left_upd;
      out_right_q   <= right_upd;
      out_missing_q <= !(seen_left_upd && seen_right_upd);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_right_q, out_left_q};
  assign m_axis_tuser  = out_missing_q;

endmodule

// ----- hdl/sdmx_checker.sv -----
module sdmx_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sdmx_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);

  // a taken speaker keeps input ready low in the first and the last of its four steps
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##3 !s_axis_tready)
    else $error("input ready during speaker processing");

  // a new result only appears at the end of a speaker's processing
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without processing");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind stereo_downmix_q15 sdmx_checker u_sdmx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
